// File: hdl/assert_macros.svh
// Assertion macros shared by the pointer motion to scroll RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PMTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define PMTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define PMTS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PMTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/pmts_pkg.sv
// Types, widths and constants of the pointer motion to scroll converter.
package pmts_pkg;

  localparam int MOTION_W    = 16;
  localparam int TIME_W      = 32;
  localparam int ACC_W       = 24;
  localparam int SUM_W       = 26;
  localparam int RATE_W      = 15;
  localparam int AXIS_W      = 28;
  localparam int FIXED_W     = 44;
  localparam int POINT_W     = 36;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = RATE_W;

  localparam int BUFFER_WINDOW_MS  = 20;
  localparam int FIXATION_RESET_MS = 300;
  localparam int FIXATION_EARLY_MS = 1000;
  localparam int FIXED_SCALE       = 65536;
  localparam int POINT_SCALE       = 10;
  localparam int RATE_UNIT         = 1024;

  localparam logic [TIME_W-1:0] BUFFER_WINDOW_T  = TIME_W'(BUFFER_WINDOW_MS);
  localparam logic [TIME_W-1:0] FIXATION_RESET_T = TIME_W'(FIXATION_RESET_MS);
  localparam logic [TIME_W-1:0] FIXATION_EARLY_T = TIME_W'(FIXATION_EARLY_MS);
  localparam logic [RATE_W-1:0] RATE_RESET       = RATE_W'(RATE_UNIT);

  localparam int RATE_SHIFT   = $clog2(RATE_UNIT);
  localparam int PROD_W       = ACC_W + RATE_W + 1;
  localparam int FIXED_MULT   = FIXED_SCALE / RATE_UNIT;
  localparam int FIXED_FULL_W = PROD_W + $clog2(FIXED_MULT) + 1;
  localparam int POINT_FULL_W = PROD_W + $clog2(POINT_SCALE) + 1;
  localparam int QUOT_W       = PROD_W - RATE_SHIFT;
  localparam int POINT_QUOT_W = POINT_FULL_W - RATE_SHIFT;
  localparam int AXIS_EXT_W   = (QUOT_W > AXIS_W) ? QUOT_W : AXIS_W;
  localparam int FIXED_EXT_W  = (FIXED_FULL_W > FIXED_W) ? FIXED_FULL_W : FIXED_W;
  localparam int POINT_EXT_W  = (POINT_QUOT_W > POINT_W) ? POINT_QUOT_W : POINT_W;

  localparam logic [CFG_INDEX_W-1:0] REG_DISABLE_VERTICAL   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_DISABLE_HORIZONTAL = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_FIXATION_ENABLE    = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_RATE        = CFG_INDEX_W'(3);

  typedef struct packed {
    logic              disable_vertical;
    logic              disable_horizontal;
    logic              fixation_enable;
    logic [RATE_W-1:0] scroll_rate;
  } cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] vert;
    logic signed [ACC_W-1:0] horz;
  } delta_pair_t;

endpackage

// File: hdl/pmts_accum.sv
// Saturating motion accumulators and the buffer window that decides when to flush.
`include "assert_macros.svh"
module pmts_accum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic signed [pmts_pkg::MOTION_W-1:0] dx_motion,
  input  logic signed [pmts_pkg::MOTION_W-1:0] dy_motion,
  input  logic        [pmts_pkg::TIME_W-1:0]   now,
  output logic                                 flush,
  output pmts_pkg::delta_pair_t                delta
);
  import pmts_pkg::*;

  logic signed [ACC_W-1:0]  acc_vertical;
  logic signed [ACC_W-1:0]  acc_horizontal;
  logic        [TIME_W-1:0] window_start;
  logic        [TIME_W-1:0] elapsed;

  // Adds the negated motion and clamps to the accumulator range.
  function automatic logic signed [ACC_W-1:0] acc_add(
    input logic signed [ACC_W-1:0]    a,
    input logic signed [MOTION_W-1:0] m
  );
    logic signed [MOTION_W:0] neg;
    logic signed [ACC_W:0]    s;
    neg = -((MOTION_W+1)'(m));
    s = (ACC_W+1)'(a) + (ACC_W+1)'(neg);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  always_comb begin
    elapsed    = now - window_start;
    flush      = elapsed >= BUFFER_WINDOW_T;
    delta.vert = acc_add(acc_vertical, dy_motion);
    delta.horz = acc_add(acc_horizontal, dx_motion);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vertical   <= '0;
      acc_horizontal <= '0;
      window_start   <= '0;
    end else if (step) begin
      if (flush) begin
        acc_vertical   <= '0;
        acc_horizontal <= '0;
        window_start   <= now;
      end else begin
        acc_vertical   <= delta.vert;
        acc_horizontal <= delta.horz;
      end
    end
  end

  `PMTS_ASSERT_NEXT(a_flush_clears, clk, rst, step && flush, acc_vertical == '0 && acc_horizontal == '0)

endmodule

// File: hdl/pmts_select.sv
// Axis disabling, minor axis suppression and the optional axis fixation stage.
`include "assert_macros.svh"
module pmts_select (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  pmts_pkg::cfg_t                    cfg,
  input  pmts_pkg::delta_pair_t             delta_in,
  input  logic [pmts_pkg::TIME_W-1:0]       now,
  output logic                              emit,
  output pmts_pkg::delta_pair_t             delta_out
);
  import pmts_pkg::*;

  logic [TIME_W-1:0]       fix_last_time;
  logic [TIME_W-1:0]       fix_begin_time;
  logic [SUM_W-1:0]        fix_sum_vertical;
  logic [SUM_W-1:0]        fix_sum_horizontal;

  logic signed [ACC_W-1:0] d1, d2, e1, e2, f1, f2;
  logic [ACC_W-1:0]        abs1, abs2;
  logic                    kill1, kill2, fkill1, fkill2;
  logic [TIME_W-1:0]       gap, since_begin, begin_eff;
  logic                    restart, early;
  logic [SUM_W-1:0]        sv_eff, sh_eff, sv_next, sh_next;

  function automatic logic [ACC_W-1:0] magnitude(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] r;
    r = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] sum_add(
    input logic [SUM_W-1:0] a,
    input logic [ACC_W-1:0] d
  );
    logic [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(d);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  always_comb begin
    d1    = cfg.disable_vertical ? '0 : delta_in.vert;
    d2    = cfg.disable_horizontal ? '0 : delta_in.horz;
    abs1  = magnitude(d1);
    abs2  = magnitude(d2);
    kill2 = {1'b0, abs1} > {abs2, 1'b0};
    kill1 = {1'b0, abs2} > {abs1, 1'b0};
    e1    = kill1 ? '0 : d1;
    e2    = kill2 ? '0 : d2;

    // A long pause starts a fresh fixation episode.
    gap         = now - fix_last_time;
    restart     = gap > FIXATION_RESET_T;
    begin_eff   = restart ? now : fix_begin_time;
    sv_eff      = restart ? '0 : fix_sum_vertical;
    sh_eff      = restart ? '0 : fix_sum_horizontal;
    fkill2      = {1'b0, sv_eff} > {sh_eff, 1'b0};
    fkill1      = {1'b0, sh_eff} > {sv_eff, 1'b0};
    since_begin = now - begin_eff;
    early       = since_begin < FIXATION_EARLY_T;

    f1 = (cfg.fixation_enable && fkill1) ? '0 : e1;
    f2 = (cfg.fixation_enable && fkill2) ? '0 : e2;

    sh_next = (early && f1 == '0) ? sum_add(sh_eff, abs2) : sh_eff;
    sv_next = (early && f2 == '0) ? sum_add(sv_eff, abs1) : sv_eff;

    emit           = (f1 != '0) || (f2 != '0);
    delta_out.vert = f1;
    delta_out.horz = f2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_last_time      <= '0;
      fix_begin_time     <= '0;
      fix_sum_vertical   <= '0;
      fix_sum_horizontal <= '0;
    end else if (step && cfg.fixation_enable) begin
      fix_last_time      <= now;
      fix_begin_time     <= begin_eff;
      fix_sum_vertical   <= sv_next;
      fix_sum_horizontal <= sh_next;
    end
  end

  `PMTS_ASSERT_NEXT(a_fix_idle, clk, rst, !(step && cfg.fixation_enable), $stable(fix_last_time) && $stable(fix_sum_vertical) && $stable(fix_sum_horizontal))

endmodule

// File: hdl/pmts_scale.sv
// Rate multiplier and scaling of one axis into line, fixed-point and point deltas.
`include "assert_macros.svh"
module pmts_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic signed [pmts_pkg::ACC_W-1:0]   d,
  input  logic        [pmts_pkg::RATE_W-1:0]  rate,
  output logic signed [pmts_pkg::AXIS_W-1:0]  axis,
  output logic signed [pmts_pkg::FIXED_W-1:0] fixed,
  output logic signed [pmts_pkg::POINT_W-1:0] point
);
  import pmts_pkg::*;

  logic signed [PROD_W-1:0]       prod;
  logic                           d_nz;
  logic                           d_neg;

  logic signed [PROD_W-1:0]       biased;
  logic signed [QUOT_W-1:0]       quot;
  logic signed [QUOT_W-1:0]       axis_q;
  logic signed [AXIS_EXT_W-1:0]   axis_ext;
  logic signed [FIXED_FULL_W-1:0] fixed_full;
  logic signed [FIXED_EXT_W-1:0]  fixed_ext;
  logic signed [POINT_FULL_W-1:0] point_full;
  logic signed [POINT_FULL_W-1:0] point_biased;
  logic signed [POINT_QUOT_W-1:0] point_quot;
  logic signed [POINT_EXT_W-1:0]  point_ext;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(d) * PROD_W'($signed({1'b0, rate}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_nz  <= 1'b0;
      d_neg <= 1'b0;
    end else if (load) begin
      d_nz  <= d != '0;
      d_neg <= d[ACC_W-1];
    end
  end

  always_comb begin
    // Division by the rate unit truncates towards zero.
    biased = prod + (prod[PROD_W-1] ? PROD_W'(RATE_UNIT - 1) : '0);
    quot   = biased[PROD_W-1:RATE_SHIFT];
    axis_q = quot;
    if (quot == '0 && d_nz) begin
      axis_q = d_neg ? '1 : QUOT_W'(1);
    end
    axis_ext = AXIS_EXT_W'(axis_q);
    if ((&axis_ext[AXIS_EXT_W-1:AXIS_W-1]) || !(|axis_ext[AXIS_EXT_W-1:AXIS_W-1])) begin
      axis = axis_ext[AXIS_W-1:0];
    end else begin
      axis = {axis_ext[AXIS_EXT_W-1], {(AXIS_W-1){~axis_ext[AXIS_EXT_W-1]}}};
    end

    fixed_full = FIXED_FULL_W'(prod) * FIXED_FULL_W'(FIXED_MULT);
    fixed_ext  = FIXED_EXT_W'(fixed_full);
    if ((&fixed_ext[FIXED_EXT_W-1:FIXED_W-1]) || !(|fixed_ext[FIXED_EXT_W-1:FIXED_W-1])) begin
      fixed = fixed_ext[FIXED_W-1:0];
    end else begin
      fixed = {fixed_ext[FIXED_EXT_W-1], {(FIXED_W-1){~fixed_ext[FIXED_EXT_W-1]}}};
    end

    point_full   = POINT_FULL_W'(prod) * POINT_FULL_W'(POINT_SCALE);
    point_biased = point_full
                 + (point_full[POINT_FULL_W-1] ? POINT_FULL_W'(RATE_UNIT - 1) : '0);
    point_quot   = point_biased[POINT_FULL_W-1:RATE_SHIFT];
    point_ext    = POINT_EXT_W'(point_quot);
    if ((&point_ext[POINT_EXT_W-1:POINT_W-1]) || !(|point_ext[POINT_EXT_W-1:POINT_W-1])) begin
      point = point_ext[POINT_W-1:0];
    end else begin
      point = {point_ext[POINT_EXT_W-1], {(POINT_W-1){~point_ext[POINT_EXT_W-1]}}};
    end
  end

  `PMTS_ASSERT_IMPLY(a_min_step, clk, rst, d_nz, axis != '0)
  `PMTS_ASSERT_IMPLY(a_sign_kept, clk, rst, d_nz, axis[AXIS_W-1] == d_neg)

endmodule

// File: hdl/pointer_motion_to_scroll.sv
// Top level of the pointer motion to scroll converter.
// A motion word passes stages s1 to s4 and then the output register. Throughput: one motion
// word per cycle while motion_ready is high; the output register and the stage valid chain
// let input words keep flowing into empty stages while a finished scroll word waits.
// Reset clears accumulators, window and fixation state, and restores the registers
// to their defaults (rate 1024, both axes enabled, fixation off); no clearing pass.
`include "assert_macros.svh"
module pointer_motion_to_scroll (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pmts_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pmts_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  motion_valid,
  output logic                                  motion_ready,
  input  logic signed [pmts_pkg::MOTION_W-1:0]  dx_motion,
  input  logic signed [pmts_pkg::MOTION_W-1:0]  dy_motion,
  input  logic        [pmts_pkg::TIME_W-1:0]    time_ms,
  output logic                                  scroll_valid,
  input  logic                                  scroll_ready,
  output logic signed [pmts_pkg::AXIS_W-1:0]    axis_vertical,
  output logic signed [pmts_pkg::AXIS_W-1:0]    axis_horizontal,
  output logic signed [pmts_pkg::FIXED_W-1:0]   fixed_vertical,
  output logic signed [pmts_pkg::FIXED_W-1:0]   fixed_horizontal,
  output logic signed [pmts_pkg::POINT_W-1:0]   point_vertical,
  output logic signed [pmts_pkg::POINT_W-1:0]   point_horizontal
);
  import pmts_pkg::*;

  cfg_t                    cfg;

  logic                    s1_valid;
  logic signed [MOTION_W-1:0] s1_dx;
  logic signed [MOTION_W-1:0] s1_dy;
  logic [TIME_W-1:0]       s1_time;
  logic                    s2_valid;
  delta_pair_t             s2_delta;
  logic [TIME_W-1:0]       s2_time;
  logic                    s3_valid;
  delta_pair_t             s3_delta;
  logic                    s4_valid;

  logic                    out_free, s4_free, s3_free, s2_free, s1_free;
  logic                    s4_go, s3_go, s2_go, s1_go;
  logic                    flush, emit;
  delta_pair_t             acc_delta, sel_delta;

  logic signed [AXIS_W-1:0]  axis_v, axis_h;
  logic signed [FIXED_W-1:0] fixed_v, fixed_h;
  logic signed [POINT_W-1:0] point_v, point_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disable_vertical   <= 1'b0;
      cfg.disable_horizontal <= 1'b0;
      cfg.fixation_enable    <= 1'b0;
      cfg.scroll_rate        <= RATE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DISABLE_VERTICAL:   cfg.disable_vertical   <= cfg_data[0];
        REG_DISABLE_HORIZONTAL: cfg.disable_horizontal <= cfg_data[0];
        REG_FIXATION_ENABLE:    cfg.fixation_enable    <= cfg_data[0];
        REG_SCROLL_RATE:        cfg.scroll_rate        <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage moves on when the one after it is empty or moving.
  always_comb begin
    out_free     = !scroll_valid || scroll_ready;
    s4_free      = !s4_valid || out_free;
    s3_free      = !s3_valid || s4_free;
    s2_free      = !s2_valid || s3_free;
    s1_free      = !s1_valid || s2_free;
    s4_go        = s4_valid && out_free;
    s3_go        = s3_valid && s4_free;
    s2_go        = s2_valid && s3_free;
    s1_go        = s1_valid && s2_free;
    motion_ready = s1_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      scroll_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= motion_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid && flush;
      end
      if (s3_free) begin
        s3_valid <= s2_valid && emit;
      end
      if (s4_free) begin
        s4_valid <= s3_valid;
      end
      if (out_free) begin
        scroll_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (motion_valid && s1_free) begin
      s1_dx   <= dx_motion;
      s1_dy   <= dy_motion;
      s1_time <= time_ms;
    end
    if (s1_go) begin
      s2_delta <= acc_delta;
      s2_time  <= s1_time;
    end
    if (s2_go) begin
      s3_delta <= sel_delta;
    end
    if (s4_go) begin
      axis_vertical    <= axis_v;
      axis_horizontal  <= axis_h;
      fixed_vertical   <= fixed_v;
      fixed_horizontal <= fixed_h;
      point_vertical   <= point_v;
      point_horizontal <= point_h;
    end
  end

  pmts_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .dx_motion (s1_dx),
    .dy_motion (s1_dy),
    .now       (s1_time),
    .flush     (flush),
    .delta     (acc_delta)
  );

  pmts_select u_select (
    .clk       (clk),
    .rst       (rst),
    .step      (s2_go),
    .cfg       (cfg),
    .delta_in  (s2_delta),
    .now       (s2_time),
    .emit      (emit),
    .delta_out (sel_delta)
  );

  pmts_scale u_scale_vertical (
    .clk   (clk),
    .rst   (rst),
    .load  (s3_go),
    .d     (s3_delta.vert),
    .rate  (cfg.scroll_rate),
    .axis  (axis_v),
    .fixed (fixed_v),
    .point (point_v)
  );

  pmts_scale u_scale_horizontal (
    .clk   (clk),
    .rst   (rst),
    .load  (s3_go),
    .d     (s3_delta.horz),
    .rate  (cfg.scroll_rate),
    .axis  (axis_h),
    .fixed (fixed_h),
    .point (point_h)
  );

  `PMTS_ASSERT_IMPLY(a_word_nonzero, clk, rst, scroll_valid, axis_vertical != '0 || axis_horizontal != '0)
  `PMTS_ASSERT_IMPLY(a_s3_from_s2, clk, rst, $rose(s3_valid), $past(s2_valid))

endmodule
